// ===== rtl/core/ssds_pkg.sv =====
package ssds_pkg;

  localparam int SampleBits   = 24;
  localparam int FractionBits = 8;
  localparam int CountBits    = 17;
  localparam int ScaleBits    = 16;

  localparam logic [CountBits-1:0] MaxSamples   = 17'h10000;
  localparam logic [ScaleBits-1:0] ScaleDefault = 16'd1000;

  typedef logic [127:0] wide_t;

  // magnitude of a 64-bit two's complement value
  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage

// ===== rtl/core/series_mean_stddev_slope.sv =====
// Running statistics over a series of (time, value) samples. Each beat may
// carry one sample; the beat marked last closes the series and produces one
// result beat: mean, population standard deviation and least-squares slope
// times slope_scale, all with 8 fraction bits, plus the sample count and a
// flag for samples dropped beyond 65536. Sums clear after each result.
// Flow: a beat without a sample is taken in ST_IDLE alone; a sample also
// passes ST_ACC_TT, ST_ACC_YY and ST_ACC_TY (one 24x24 multiplier forms
// t*t, y*y and t*y in turn). The closing beat then runs on a shared 128-bit
// datapath under a sequencer: up to eight 64-step shift-add multiplies, up
// to three 128-step restoring divides and a 32-step square root. A new
// series can start while the result beat still waits on the output.
module series_mean_stddev_slope (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ssds_pkg::ScaleBits-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ssds_pkg::SampleBits-1:0] sample_time_i,
  input  logic signed [ssds_pkg::SampleBits-1:0] sample_value_i,
  input  logic                                has_sample_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [31:0]                  mean_value_o,
  output logic [31:0]                         stddev_value_o,
  output logic signed [47:0]                  drift_o,
  output logic                                drift_valid_o,
  output logic [ssds_pkg::CountBits-1:0]      sample_count_o,
  output logic                                overflowed_o
);
  import ssds_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC_TT, ST_ACC_YY, ST_ACC_TY, ST_NEXT,
    ST_MUL, ST_DIV, ST_SQRT, ST_POST, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    K_MEAN, K_NN, K_NVV, K_VV, K_SDIV, K_SQRT,
    K_NTV, K_TV, K_NTT, K_TT, K_SC, K_DDIV
  } step_e;

  state_e st_q;
  step_e  step_q;

  logic [ScaleBits-1:0] scale_q;
  logic [CountBits-1:0] count_q;
  logic signed [40:0]   sum_t_q, sum_v_q;
  logic [63:0]          sum_tt_q, sum_vv_q, sum_tv_q;
  logic                 drop_q, last_q;

  logic [SampleBits-1:0] mt_q, my_q;
  logic                  nt_q, ny_q;

  logic [6:0]  cnt_q;
  logic [63:0] ua_q;
  wide_t       ub_q, acc_q, quo_q, den_q, t1_q, t2_q;
  logic        neg_q, dneg_q;

  logic [31:0] mean_q, sd_q;
  logic [47:0] drift_q;
  logic        dvalid_q;

  logic        out_valid_q;
  logic [31:0] out_mean_q, out_sd_q;
  logic [47:0] out_drift_q;
  logic        out_dvalid_q, out_drop_q;
  logic [CountBits-1:0] out_count_q;

  // sample capture
  logic signed [SampleBits-1:0] t_s, y_s;
  logic [SampleBits-1:0]        mt_s, my_s;
  assign t_s  = sample_time_i;
  assign y_s  = sample_value_i;
  assign mt_s = t_s[SampleBits-1] ? (~t_s + 1'b1) : t_s;
  assign my_s = y_s[SampleBits-1] ? (~y_s + 1'b1) : y_s;

  // shared sample multiplier
  logic [SampleBits-1:0]   pm_a, pm_b;
  logic [2*SampleBits-1:0] pm;
  always_comb begin
    pm_a = mt_q;
    pm_b = mt_q;
    if (st_q == ST_ACC_YY) begin
      pm_a = my_q;
      pm_b = my_q;
    end else if (st_q == ST_ACC_TY) begin
      pm_b = my_q;
    end
  end
  assign pm = pm_a * pm_b;

  logic [63:0] pm64, pm_tv;
  assign pm64  = {{(64-2*SampleBits){1'b0}}, pm};
  assign pm_tv = (nt_q != ny_q) ? (~pm64 + 64'd1) : pm64;

  // wide operands
  logic [63:0] n64, st64, sv64, sv_mag;
  assign n64    = {{(64-CountBits){1'b0}}, count_q};
  assign st64   = {{23{sum_t_q[40]}}, sum_t_q};
  assign sv64   = {{23{sum_v_q[40]}}, sum_v_q};
  assign sv_mag = mag64(sv64);

  // shared 128-bit datapath
  wide_t rem_sh, rem_sub, prod, t1_mag;
  logic  rem_ge;
  logic [63:0] sq_try;
  logic        sq_ge;
  assign rem_sh  = {acc_q[126:0], quo_q[127]};
  assign rem_ge  = rem_sh >= den_q;
  assign rem_sub = rem_sh - den_q;
  assign sq_try  = quo_q[63:0] + ub_q[63:0];
  assign sq_ge   = acc_q[63:0] >= sq_try;
  assign prod    = neg_q ? (~acc_q + 128'd1) : acc_q;
  assign t1_mag  = t1_q[127] ? (~t1_q + 128'd1) : t1_q;

  wide_t lim;
  assign lim = dneg_q ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;

  logic start;
  assign start = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      step_q      <= K_MEAN;
      scale_q     <= ScaleDefault;
      count_q     <= '0;
      sum_t_q     <= '0;
      sum_v_q     <= '0;
      sum_tt_q    <= '0;
      sum_vv_q    <= '0;
      sum_tv_q    <= '0;
      drop_q      <= 1'b0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (start) begin
            last_q <= last_i;
            step_q <= K_MEAN;
            if (has_sample_i && count_q != MaxSamples) begin
              count_q <= count_q + 1'b1;
              sum_t_q <= sum_t_q + 41'(t_s);
              sum_v_q <= sum_v_q + 41'(y_s);
              mt_q    <= mt_s;
              my_q    <= my_s;
              nt_q    <= t_s[SampleBits-1];
              ny_q    <= y_s[SampleBits-1];
              st_q    <= ST_ACC_TT;
            end else begin
              if (has_sample_i) drop_q <= 1'b1;
              if (last_i) st_q <= ST_NEXT;
            end
          end
        end
        ST_ACC_TT: begin
          sum_tt_q <= sum_tt_q + pm64;
          st_q     <= ST_ACC_YY;
        end
        ST_ACC_YY: begin
          sum_vv_q <= sum_vv_q + pm64;
          st_q     <= ST_ACC_TY;
        end
        ST_ACC_TY: begin
          sum_tv_q <= sum_tv_q + pm_tv;
          st_q     <= last_q ? ST_NEXT : ST_IDLE;
        end
        ST_NEXT: begin
          // operand setup for the current step
          acc_q <= (step_q == K_SQRT) ?
                   {64'd0, (t1_q[127:64] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF : t1_q[63:0]} :
                   '0;
          neg_q <= (step_q == K_NTV) ? sum_tv_q[63] :
                   (step_q == K_TV)  ? (st64[63] ^ sv64[63]) : 1'b0;
          case (step_q)
            K_MEAN: begin
              if (count_q == '0) begin
                mean_q   <= '0;
                sd_q     <= '0;
                drift_q  <= '0;
                dvalid_q <= 1'b0;
                st_q     <= ST_DONE;
              end else begin
                quo_q <= {64'd0, sv_mag << FractionBits};
                den_q <= {64'd0, n64};
                cnt_q <= 7'd127;
                st_q  <= ST_DIV;
              end
            end
            K_NN, K_NVV, K_NTT: begin
              ua_q  <= n64;
              ub_q  <= {64'd0, (step_q == K_NN)  ? n64 :
                               (step_q == K_NVV) ? sum_vv_q : sum_tt_q};
              cnt_q <= 7'd63;
              st_q  <= ST_MUL;
            end
            K_VV: begin
              ua_q  <= sv_mag;
              ub_q  <= {64'd0, sv_mag};
              cnt_q <= 7'd63;
              st_q  <= ST_MUL;
            end
            K_NTV: begin
              ua_q  <= n64;
              ub_q  <= {64'd0, mag64(sum_tv_q)};
              cnt_q <= 7'd63;
              st_q  <= ST_MUL;
            end
            K_TV: begin
              ua_q  <= mag64(st64);
              ub_q  <= {64'd0, sv_mag};
              cnt_q <= 7'd63;
              st_q  <= ST_MUL;
            end
            K_TT: begin
              ua_q  <= mag64(st64);
              ub_q  <= {64'd0, mag64(st64)};
              cnt_q <= 7'd63;
              st_q  <= ST_MUL;
            end
            K_SDIV: begin
              if (t1_q[127]) begin
                sd_q   <= '0;
                step_q <= K_NTV;
              end else begin
                quo_q <= t1_q << (2*FractionBits);
                den_q <= t2_q;
                cnt_q <= 7'd127;
                st_q  <= ST_DIV;
              end
            end
            K_SQRT: begin
              quo_q <= '0;
              ub_q  <= {64'd0, 64'h4000_0000_0000_0000};
              cnt_q <= 7'd31;
              st_q  <= ST_SQRT;
            end
            K_SC: begin
              if (t2_q[127] || t2_q == '0) begin
                drift_q  <= '0;
                dvalid_q <= 1'b0;
                st_q     <= ST_DONE;
              end else begin
                dneg_q <= t1_q[127];
                ua_q   <= {{(64-ScaleBits){1'b0}}, scale_q};
                ub_q   <= t1_mag;
                cnt_q  <= 7'd63;
                st_q   <= ST_MUL;
              end
            end
            K_DDIV: begin
              quo_q <= t1_q << FractionBits;
              den_q <= t2_q;
              cnt_q <= 7'd127;
              st_q  <= ST_DIV;
            end
            default: st_q <= ST_DONE;
          endcase
        end
        ST_MUL: begin
          if (ua_q[0]) acc_q <= acc_q + ub_q;
          ua_q  <= ua_q >> 1;
          ub_q  <= ub_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) st_q <= ST_POST;
        end
        ST_DIV: begin
          acc_q <= rem_ge ? rem_sub : rem_sh;
          quo_q <= {quo_q[126:0], rem_ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) st_q <= ST_POST;
        end
        ST_SQRT: begin
          if (sq_ge) begin
            acc_q[63:0] <= acc_q[63:0] - sq_try;
            quo_q[63:0] <= (quo_q[63:0] >> 1) + ub_q[63:0];
          end else begin
            quo_q[63:0] <= quo_q[63:0] >> 1;
          end
          ub_q[63:0] <= ub_q[63:0] >> 2;
          cnt_q      <= cnt_q - 1'b1;
          if (cnt_q == '0) st_q <= ST_POST;
        end
        ST_POST: begin
          st_q <= (step_q == K_DDIV) ? ST_DONE : ST_NEXT;
          case (step_q)
            K_MEAN: begin
              mean_q <= sum_v_q[40] ? (~quo_q[31:0] + 32'd1) : quo_q[31:0];
              step_q <= K_NN;
            end
            K_NN:   begin t2_q <= prod;        step_q <= K_NVV;  end
            K_NVV:  begin t1_q <= prod;        step_q <= K_VV;   end
            K_VV:   begin t1_q <= t1_q - prod; step_q <= K_SDIV; end
            K_SDIV: begin t1_q <= quo_q;       step_q <= K_SQRT; end
            K_SQRT: begin sd_q <= quo_q[31:0]; step_q <= K_NTV;  end
            K_NTV:  begin t1_q <= prod;        step_q <= K_TV;   end
            K_TV:   begin t1_q <= t1_q - prod; step_q <= K_NTT;  end
            K_NTT:  begin t2_q <= prod;        step_q <= K_TT;   end
            K_TT:   begin t2_q <= t2_q - prod; step_q <= K_SC;   end
            K_SC:   begin t1_q <= prod;        step_q <= K_DDIV; end
            K_DDIV: begin
              if (quo_q > lim) begin
                drift_q <= dneg_q ? (~lim[47:0] + 48'd1) : lim[47:0];
              end else begin
                drift_q <= dneg_q ? (~quo_q[47:0] + 48'd1) : quo_q[47:0];
              end
              dvalid_q <= 1'b1;
            end
            default: ;
          endcase
        end
        ST_DONE: begin
          if (!out_valid_q) begin
            out_valid_q  <= 1'b1;
            out_mean_q   <= mean_q;
            out_sd_q     <= sd_q;
            out_drift_q  <= drift_q;
            out_dvalid_q <= dvalid_q;
            out_count_q  <= count_q;
            out_drop_q   <= drop_q;
            count_q      <= '0;
            sum_t_q      <= '0;
            sum_v_q      <= '0;
            sum_tt_q     <= '0;
            sum_vv_q     <= '0;
            sum_tv_q     <= '0;
            drop_q       <= 1'b0;
            st_q         <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mean_value_o   = out_mean_q;
  assign stddev_value_o = out_sd_q;
  assign drift_o        = out_drift_q;
  assign drift_valid_o  = out_dvalid_q;
  assign sample_count_o = out_count_q;
  assign overflowed_o   = out_drop_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxSamples)
    else $error("sample count beyond capacity");

  a_drift_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && drift_valid_o) |-> (sample_count_o >= 17'd2))
    else $error("slope flagged valid with fewer than two samples");

  a_done_issues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && !out_valid_q) |=> (out_valid_q && st_q == ST_IDLE))
    else $error("finished result not issued");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MUL || st_q == ST_DIV || st_q == ST_SQRT) |-> !in_ready_o)
    else $error("input ready while sequencer busy");

endmodule

// ===== verif/series_stats_checker.sv =====
`timescale 1ns / 100ps

module series_stats_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [23:0] sample_time_i,
  input  logic signed [23:0] sample_value_i,
  input  logic               has_sample_i,
  input  logic               last_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] mean_value_i,
  input  logic [31:0]        stddev_value_i,
  input  logic signed [47:0] drift_i,
  input  logic               drift_valid_i,
  input  logic [16:0]        sample_count_i,
  input  logic               overflowed_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [31:0] mean;
    logic [31:0] stddev;
    logic [47:0] drift;
    logic        drift_ok;
    logic [16:0] count;
    logic        dropped;
  } stats_t;

  stats_t stats_q[$];

  logic [15:0]         scale;
  logic [16:0]         n_samples;
  logic signed [127:0] s_t, s_tt, s_y, s_yy, s_ty;
  logic                dropped;

  assign pending_o = stats_q.size();

  function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
    logic [127:0] r;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      if ((r | (128'd1 << b)) * (r | (128'd1 << b)) <= x) r |= 128'd1 << b;
    end
    return r[63:0];
  endfunction

  function automatic stats_t series_stats();
    stats_t s;
    logic signed [127:0] n, d, nt, dt, mg, q;
    logic [127:0] uq;
    logic [63:0]  root;
    logic         neg;
    s = '0;
    n = n_samples;
    s.count = n_samples;
    s.dropped = dropped;
    if (n_samples != 0) begin
      mg = s_y < 0 ? -s_y : s_y;
      q = (mg <<< 8) / n;
      s.mean = s_y < 0 ? -q[31:0] : q[31:0];
      d = n * s_yy - s_y * s_y;
      if (d >= 0) begin
        uq = (d <<< 16) / (n * n);
        root = floor_sqrt(uq[127:64] != 0 ? 128'hFFFF_FFFF_FFFF_FFFF : uq);
        s.stddev = root > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : root[31:0];
      end
      nt = n * s_ty - s_t * s_y;
      dt = n * s_tt - s_t * s_t;
      if (dt > 0) begin
        neg = nt < 0;
        mg = neg ? -nt : nt;
        q = ((mg * $signed({1'b0, scale})) <<< 8) / dt;
        if (neg) begin
          if (q > (128'sd1 <<< 47)) q = 128'sd1 <<< 47;
          q = -q;
        end else if (q > (128'sd1 <<< 47) - 1) q = (128'sd1 <<< 47) - 1;
        s.drift = q[47:0];
        s.drift_ok = 1'b1;
      end
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stats_t e;
    logic signed [127:0] t, y;
    if (!rst_ni) begin
      fail_count_o = 0;
      scale = 16'd1000;
      n_samples = 0;
      {s_t, s_tt, s_y, s_yy, s_ty} = '0;
      dropped = 0;
    end else begin
      if (cfg_we_i) scale = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (stats_q.size() == 0) report_mismatch("unexpected result beat", 0, 0);
        else begin
          e = stats_q.pop_front();
          if (mean_value_i !== e.mean) report_mismatch("mean", mean_value_i, e.mean);
          if (stddev_value_i !== e.stddev)
            report_mismatch("stddev", stddev_value_i, e.stddev);
          if (drift_i !== e.drift) report_mismatch("drift", drift_i, e.drift);
          if (drift_valid_i !== e.drift_ok)
            report_mismatch("drift_valid", drift_valid_i, e.drift_ok);
          if (sample_count_i !== e.count)
            report_mismatch("sample_count", sample_count_i, e.count);
          if (overflowed_i !== e.dropped)
            report_mismatch("overflowed", overflowed_i, e.dropped);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (has_sample_i) begin
          if (n_samples < 17'h10000) begin
            t = sample_time_i;
            y = sample_value_i;
            n_samples++;
            s_t += t; s_y += y;
            s_tt += t * t; s_yy += y * y; s_ty += t * y;
          end else dropped = 1;
        end
        if (last_i) begin
          stats_q.push_back(series_stats());
          n_samples = 0;
          {s_t, s_tt, s_y, s_yy, s_ty} = '0;
          dropped = 0;
        end
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  logic               clk_i, rst_ni;
  logic               cfg_we_i;
  logic [15:0]        cfg_wdata_i;
  logic               in_valid_i, in_ready_o;
  logic signed [23:0] sample_time_i, sample_value_i;
  logic               has_sample_i, last_i;
  logic               out_valid_o, out_ready_i;
  logic signed [31:0] mean_value_o;
  logic [31:0]        stddev_value_o;
  logic signed [47:0] drift_o;
  logic               drift_valid_o;
  logic [16:0]        sample_count_o;
  logic               overflowed_o;
  int                 fail_count, pending;
  int                 cycles;
  bit                 calm;

  localparam int CycleLimit = 20_000_000;

  series_mean_stddev_slope u_top (.*);

  series_stats_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_ready_i(in_ready_o), .sample_time_i, .sample_value_i, .has_sample_i,
    .last_i, .out_valid_i(out_valid_o), .out_ready_i,
    .mean_value_i(mean_value_o), .stddev_value_i(stddev_value_o),
    .drift_i(drift_o), .drift_valid_i(drift_valid_o),
    .sample_count_i(sample_count_o), .overflowed_i(overflowed_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("series_mean_stddev_slope verification failed");
        $finish;
      end
    end
  end

  // result side stalls at random unless calm is set
  always @(negedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 35);

  // valid stays up across back-to-back beats; it drops only while idling
  task automatic send_beat(input logic signed [23:0] t, input logic signed [23:0] y,
                           input logic hs, input logic lst);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1; sample_time_i <= t; sample_value_i <= y;
    has_sample_i <= hs; last_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (1200) @(negedge clk_i);
  endtask

  task automatic set_scale(input logic [15:0] v);
    drain();
    cfg_we_i <= 1; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic signed [23:0] rnd24();
    case ($urandom_range(5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return $signed(24'($urandom_range(15))) - 24'sd8;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_series(input int len);
    for (int i = 0; i < len; i++)
      send_beat(rnd24(), rnd24(), $urandom_range(9) != 0, i == len - 1);
  endtask

  initial begin
    int lens;
    rst_ni = 0; cfg_we_i = 0; cfg_wdata_i = 0; in_valid_i = 0;
    sample_time_i = 0; sample_value_i = 0; has_sample_i = 0; last_i = 0;
    calm = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed: empty series, one sample, equal times, extremes
    send_beat(0, 0, 0, 1);
    send_beat(5, -7, 1, 1);
    send_beat(3, 100, 1, 0); send_beat(3, -50, 1, 0); send_beat(3, 9, 1, 1);
    send_beat(24'sh800000, 24'sh7FFFFF, 1, 0);
    send_beat(24'sh7FFFFF, 24'sh800000, 1, 0); send_beat(0, 0, 0, 1);
    send_beat(24'sh800000, 24'sh800000, 1, 0);
    send_beat(24'sh7FFFFF, 24'sh7FFFFF, 1, 1);
    send_beat(1, 1, 1, 0); send_beat(2, 3, 1, 0); send_beat(3, 5, 1, 1);
    set_scale(16'hFFFF);
    send_beat(0, 24'sh800000, 1, 0); send_beat(1, 24'sh7FFFFF, 1, 1);
    send_beat(24'sh800000, 24'sh7FFFFF, 1, 0); send_beat(24'sh7FFFFF, 24'sh800000, 1, 1);
    set_scale(0);
    send_beat(1, 4, 1, 0); send_beat(9, -4, 1, 1);
    // sender holds off until all results are back
    drain();
    set_scale(16'd1000);
    lens = 0;
    while (lens < 1600) begin
      int len;
      if (lens > 600 && lens < 900) calm = 1; else calm = 0;
      if (lens > 1100 && lens < 1150) set_scale(16'($urandom));
      len = $urandom_range(1, 12);
      random_series(len);
      lens += len;
    end
    set_scale(16'd1);
    random_series(40);
    drain();
    if (fail_count == 0) $display("series_mean_stddev_slope verification clean");
    else $display("series_mean_stddev_slope verification failed");
    $finish;
  end

endmodule
